// ===== hdl/ptd_pkg.sv =====
// Shared constants and codes for the periodic task dispatcher.
package ptd_pkg;

   localparam int NUM_TASKS  = 3;
   localparam int MAX_TASKS  = 4;
   localparam int TASK_IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W      = 16;
   localparam int CSR_IDX_W  = $clog2(2 * MAX_TASKS);
   localparam int REQ_W      = 2;
   localparam int ST_W       = 2;

   localparam logic [CNT_W-1:0]      CSR_RESET_VALUE = CNT_W'(1000);
   localparam logic [TASK_IDX_W-1:0] LAST_TASK       = TASK_IDX_W'(NUM_TASKS - 1);

   // Task state codes.
   localparam logic [ST_W-1:0] ST_SUSPENDED    = 2'd0;
   localparam logic [ST_W-1:0] ST_READY        = 2'd1;
   localparam logic [ST_W-1:0] ST_RUNNING      = 2'd2;
   localparam logic [ST_W-1:0] ST_NOT_FINISHED = 2'd3;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_TICK     = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DISPATCH = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DONE     = 2'd2;

endpackage

// ===== hdl/periodic_task_dispatcher.sv =====
// Periodic task dispatcher: per-task tick counters in a small RAM, task states in flops.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------------
//   req      | req_valid/req_ready | req_type, req_done_task
//   rsp      | rsp_valid/rsp_ready | rsp_grant_valid, rsp_grant_task,
//            |                     | rsp_ready_mask, rsp_overrun_mask
//   csr      | csr_we              | csr_index, csr_wdata
//
// In a tick beat the counter RAM is read one entry ahead while the previous
// entry is updated and written back, one task per cycle. Dispatch, done and
// unused request beats skip the counter walk and go straight to the response.
// Reset clears the FSM, the task states, the RAM entry valid bits and the
// registers to 1000; an entry whose valid bit is clear reads as zero.
// One beat is in work at a time; a finished result waits in the output
// register while the next request beat is accepted.
module periodic_task_dispatcher
   import ptd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [REQ_W-1:0]      req_type,
   input  logic [TASK_IDX_W-1:0] req_done_task,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_grant_valid,
   output logic [TASK_IDX_W-1:0] rsp_grant_task,
   output logic [MAX_TASKS-1:0]  rsp_ready_mask,
   output logic [MAX_TASKS-1:0]  rsp_overrun_mask,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CNT_W-1:0]      csr_wdata
);

   localparam logic [1:0] FSM_IDLE = 2'd0;
   localparam logic [1:0] FSM_TICK = 2'd1;
   localparam logic [1:0] FSM_RESP = 2'd2;

   logic [1:0]            fsm_ff, fsm_in;
   logic [TASK_IDX_W-1:0] idx_ff, idx_in;
   logic [ST_W-1:0]       task_state_ff [MAX_TASKS];
   logic [ST_W-1:0]       task_state_in [MAX_TASKS];
   logic [CNT_W-1:0]      period_ff     [MAX_TASKS];
   logic [CNT_W-1:0]      deadline_ff   [MAX_TASKS];
   logic                  grant_vld_ff, grant_vld_in;
   logic [TASK_IDX_W-1:0] grant_task_ff, grant_task_in;

   // Counter RAM with one valid bit per entry.
   logic [CNT_W-1:0]      cnt_mem [MAX_TASKS];
   logic [MAX_TASKS-1:0]  cnt_vld_ff;
   logic [CNT_W-1:0]      rd_data_ff;
   logic                  rd_vld_ff;
   logic [TASK_IDX_W-1:0] rd_addr;
   logic                  wr_en;
   logic [CNT_W-1:0]      wr_data;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_grant_valid_ff;
   logic [TASK_IDX_W-1:0] rsp_grant_task_ff;
   logic [MAX_TASKS-1:0]  rsp_ready_mask_ff, rsp_overrun_mask_ff;
   logic                  rsp_load;

   logic                  req_fire;
   logic                  out_free;
   logic [CNT_W-1:0]      cur_cnt, dl_match, pe_match;
   logic [ST_W-1:0]       cur_st, upd_st;
   logic                  pick_found;
   logic [TASK_IDX_W-1:0] pick_idx;
   logic [MAX_TASKS-1:0]  ready_mask, overrun_mask;

   assign req_ready = (fsm_ff == FSM_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // The first entry is fetched as the tick beat is accepted; afterwards the
   // next entry is fetched while the current one is written back.
   assign rd_addr = (fsm_ff == FSM_IDLE) ? '0 : idx_ff + TASK_IDX_W'(1);
   assign wr_en   = (fsm_ff == FSM_TICK);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem[idx_ff] <= wr_data;
      end
      rd_data_ff <= cnt_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= cnt_vld_ff[rd_addr];
         if (wr_en) begin
            cnt_vld_ff[idx_ff] <= 1'b1;
         end
      end
   end

   // Per-task update of one tick.
   always_comb begin
      cur_cnt  = rd_vld_ff ? rd_data_ff : '0;
      cur_st   = task_state_ff[idx_ff];
      dl_match = deadline_ff[idx_ff] - CNT_W'(1);
      pe_match = period_ff[idx_ff] - CNT_W'(1);
      upd_st   = cur_st;
      if (cur_cnt == dl_match && (cur_st == ST_RUNNING || cur_st == ST_NOT_FINISHED)) begin
         upd_st = ST_NOT_FINISHED;
      end
      if (cur_cnt == pe_match) begin
         upd_st  = ST_READY;
         wr_data = '0;
      end else begin
         wr_data = cur_cnt + CNT_W'(1);
      end
   end

   // Lowest-index ready task.
   always_comb begin
      pick_found = 1'b0;
      pick_idx   = '0;
      for (int i = NUM_TASKS - 1; i >= 0; i--) begin
         if (task_state_ff[i] == ST_READY) begin
            pick_found = 1'b1;
            pick_idx   = TASK_IDX_W'(i);
         end
      end
   end

   always_comb begin
      ready_mask   = '0;
      overrun_mask = '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
         ready_mask[i]   = (task_state_ff[i] == ST_READY);
         overrun_mask[i] = (task_state_ff[i] == ST_NOT_FINISHED);
      end
   end

   always_comb begin
      fsm_in        = fsm_ff;
      idx_in        = idx_ff;
      grant_vld_in  = grant_vld_ff;
      grant_task_in = grant_task_ff;
      rsp_load      = 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         task_state_in[i] = task_state_ff[i];
      end
      unique case (fsm_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               grant_vld_in  = 1'b0;
               grant_task_in = '0;
               idx_in        = '0;
               unique case (req_type)
                  REQ_TICK: begin
                     fsm_in = FSM_TICK;
                  end
                  REQ_DISPATCH: begin
                     fsm_in = FSM_RESP;
                     if (pick_found) begin
                        grant_vld_in            = 1'b1;
                        grant_task_in           = pick_idx;
                        task_state_in[pick_idx] = ST_RUNNING;
                     end
                  end
                  REQ_DONE: begin
                     fsm_in = FSM_RESP;
                     if ({1'b0, req_done_task} < (TASK_IDX_W + 1)'(NUM_TASKS)) begin
                        task_state_in[req_done_task] = ST_SUSPENDED;
                     end
                  end
                  default: begin
                     fsm_in = FSM_RESP;
                  end
               endcase
            end
         end
         FSM_TICK: begin
            task_state_in[idx_ff] = upd_st;
            idx_in                = idx_ff + TASK_IDX_W'(1);
            if (idx_ff == LAST_TASK) begin
               fsm_in = FSM_RESP;
            end
         end
         FSM_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               fsm_in   = FSM_IDLE;
            end
         end
         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= FSM_IDLE;
         idx_ff        <= '0;
         grant_vld_ff  <= 1'b0;
         grant_task_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            task_state_ff[i] <= ST_SUSPENDED;
         end
      end else begin
         fsm_ff        <= fsm_in;
         idx_ff        <= idx_in;
         grant_vld_ff  <= grant_vld_in;
         grant_task_ff <= grant_task_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int i = 0; i < MAX_TASKS; i++) begin
            task_state_ff[i] <= task_state_in[i];
         end
      end
   end

   // Period and deadline registers; an index beyond the list does not exist
   // at this index width.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            period_ff[i]   <= CSR_RESET_VALUE;
            deadline_ff[i] <= CSR_RESET_VALUE;
         end
      end else if (csr_we) begin
         if (csr_index[0]) begin
            deadline_ff[csr_index[CSR_IDX_W-1:1]] <= csr_wdata;
         end else begin
            period_ff[csr_index[CSR_IDX_W-1:1]] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_grant_valid_ff  <= grant_vld_ff;
         rsp_grant_task_ff   <= grant_task_ff;
         rsp_ready_mask_ff   <= ready_mask;
         rsp_overrun_mask_ff <= overrun_mask;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_grant_valid  = rsp_grant_valid_ff;
   assign rsp_grant_task   = rsp_grant_task_ff;
   assign rsp_ready_mask   = rsp_ready_mask_ff;
   assign rsp_overrun_mask = rsp_overrun_mask_ff;

endmodule

// ===== tb/sv/ptd_checker.sv =====
// Scoreboard for the periodic task dispatcher: predicts every result beat and compares it.
module ptd_checker
   import ptd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [REQ_W-1:0]      req_type,
   input  logic [TASK_IDX_W-1:0] req_done_task,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_grant_valid,
   input  logic [TASK_IDX_W-1:0] rsp_grant_task,
   input  logic [MAX_TASKS-1:0]  rsp_ready_mask,
   input  logic [MAX_TASKS-1:0]  rsp_overrun_mask,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CNT_W-1:0]      csr_wdata,
   output int                    mismatch_count,
   output int                    results_pending
);

   typedef struct packed {
      logic                  grant_valid;
      logic [TASK_IDX_W-1:0] grant_task;
      logic [MAX_TASKS-1:0]  ready_mask;
      logic [MAX_TASKS-1:0]  overrun_mask;
   } sched_result_type;

   logic [CNT_W-1:0] period_cfg   [MAX_TASKS];
   logic [CNT_W-1:0] deadline_cfg [MAX_TASKS];
   logic [CNT_W-1:0] tick_cnt     [MAX_TASKS];
   logic [ST_W-1:0]  task_st      [MAX_TASKS];

   sched_result_type expected_sched[$];
   int               miss_total = 0;

   assign mismatch_count = miss_total;

   // Advances the task table by one request and returns the result it reports.
   task automatic schedule_step(input logic [REQ_W-1:0] kind,
                                input logic [TASK_IDX_W-1:0] which,
                                output sched_result_type r);
      logic [CNT_W-1:0] deadline_hit;
      logic [CNT_W-1:0] period_hit;
      bit               granted;
      r = '0;
      granted = 1'b0;
      case (kind)
         REQ_TICK: begin
            for (int i = 0; i < NUM_TASKS; i++) begin
               // Both compares wrap in 16 bits, so a zero setting acts as 65536.
               deadline_hit = deadline_cfg[i] - CNT_W'(1);
               period_hit   = period_cfg[i] - CNT_W'(1);
               if (tick_cnt[i] == deadline_hit &&
                   (task_st[i] == ST_RUNNING || task_st[i] == ST_NOT_FINISHED))
                  task_st[i] = ST_NOT_FINISHED;
               if (tick_cnt[i] == period_hit) begin
                  task_st[i]  = ST_READY;
                  tick_cnt[i] = '0;
               end else begin
                  tick_cnt[i] = tick_cnt[i] + CNT_W'(1);
               end
            end
         end
         REQ_DISPATCH: begin
            for (int i = 0; i < NUM_TASKS; i++) begin
               if (!granted && task_st[i] == ST_READY) begin
                  task_st[i]    = ST_RUNNING;
                  granted       = 1'b1;
                  r.grant_valid = 1'b1;
                  r.grant_task  = TASK_IDX_W'(i);
               end
            end
         end
         REQ_DONE: begin
            if (int'(which) < NUM_TASKS)
               task_st[which] = ST_SUSPENDED;
         end
         default: ;
      endcase
      for (int i = 0; i < NUM_TASKS; i++) begin
         r.ready_mask[i]   = (task_st[i] == ST_READY);
         r.overrun_mask[i] = (task_st[i] == ST_NOT_FINISHED);
      end
   endtask

   always @(posedge clock) begin : monitor
      sched_result_type      want;
      sched_result_type      got;
      logic [TASK_IDX_W-1:0] cfg_task;
      logic                  cfg_is_deadline;
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            period_cfg[i]   = CSR_RESET_VALUE;
            deadline_cfg[i] = CSR_RESET_VALUE;
            tick_cnt[i]     = '0;
            task_st[i]      = ST_SUSPENDED;
         end
         expected_sched.delete();
      end else begin
         if (csr_we) begin
            {cfg_task, cfg_is_deadline} = csr_index;
            if (cfg_is_deadline)
               deadline_cfg[cfg_task] = csr_wdata;
            else
               period_cfg[cfg_task] = csr_wdata;
         end
         // The result beat leaving now always belongs to an older request.
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_grant_valid, rsp_grant_task, rsp_ready_mask, rsp_overrun_mask};
            if (expected_sched.size() == 0) begin
               if (miss_total < 10) begin
                  $write("%0t: result beat with nothing expected: ", $time);
                  $display("grant %b/%0d ready %b overrun %b", got.grant_valid,
                           got.grant_task, got.ready_mask, got.overrun_mask);
               end
               miss_total++;
            end else begin
               want = expected_sched.pop_front();
               if (got.grant_valid !== want.grant_valid || got.grant_task !== want.grant_task ||
                   got.ready_mask !== want.ready_mask ||
                   got.overrun_mask !== want.overrun_mask) begin
                  if (miss_total < 10) begin
                     $write("%0t: expected grant %b/%0d ready %b overrun %b, ", $time,
                            want.grant_valid, want.grant_task, want.ready_mask,
                            want.overrun_mask);
                     $display("got grant %b/%0d ready %b overrun %b", got.grant_valid,
                              got.grant_task, got.ready_mask, got.overrun_mask);
                  end
                  miss_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            schedule_step(req_type, req_done_task, want);
            expected_sched.push_back(want);
         end
      end
      results_pending <= expected_sched.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// Stimulus and verdict for the periodic task dispatcher testbench.
module tb;
   import ptd_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int DRAIN_CYCLES = NUM_TASKS + 8;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 200;

   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   // Register index = {task, select}; the select bit picks period or deadline.
   localparam logic CSR_PERIOD_SEL   = 1'b0;
   localparam logic CSR_DEADLINE_SEL = 1'b1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [REQ_W-1:0]      req_type = REQ_TICK;
   logic [TASK_IDX_W-1:0] req_done_task = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_grant_valid;
   logic [TASK_IDX_W-1:0] rsp_grant_task;
   logic [MAX_TASKS-1:0]  rsp_ready_mask;
   logic [MAX_TASKS-1:0]  rsp_overrun_mask;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CNT_W-1:0]      csr_wdata = '0;
   int                    mismatch_count;
   int                    results_pending;

   bit                    calm = 1'b0;
   int                    stall_left = 0;
   logic [CNT_W-1:0]      next_period   [MAX_TASKS];
   logic [CNT_W-1:0]      next_deadline [MAX_TASKS];

   periodic_task_dispatcher uut (.*);
   ptd_checker scoreboard (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(negedge clock) begin
      if (calm || stall_left == 0) begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
      end else begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end
   end

   task automatic issue(input logic [REQ_W-1:0] kind, input logic [TASK_IDX_W-1:0] which);
      int gap;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_done_task <= which;
      do @(posedge clock); while (!req_ready);
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Registers are only written once the dispatcher has drained.
   task automatic apply_schedule();
      wait_idle();
      for (int t = 0; t < MAX_TASKS; t++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= {TASK_IDX_W'(t), CSR_PERIOD_SEL};
         csr_wdata <= next_period[t];
         @(negedge clock);
         csr_index <= {TASK_IDX_W'(t), CSR_DEADLINE_SEL};
         csr_wdata <= next_deadline[t];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int r;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Nothing is ready yet; done beats on every index, including the absent task.
      issue(REQ_DISPATCH, 2'd0);
      for (int t = 0; t < MAX_TASKS; t++)
         issue(REQ_DONE, TASK_IDX_W'(t));
      issue(REQ_UNUSED, 2'd3);

      next_period   = '{16'd1, 16'd2, 16'd3, 16'd65535};
      next_deadline = '{16'd1, 16'd1, 16'd2, 16'd65535};
      apply_schedule();
      // A running task that hits its deadline on the tick it becomes ready again.
      repeat (3) begin
         issue(REQ_TICK, 2'd0);
         issue(REQ_DISPATCH, 2'd0);
      end
      repeat (2) issue(REQ_TICK, 2'd3);
      repeat (2) issue(REQ_DISPATCH, 2'd1);
      repeat (3) issue(REQ_TICK, 2'd0);
      issue(REQ_DONE, 2'd2);
      issue(REQ_DONE, 2'd3);
      issue(REQ_UNUSED, 2'd0);
      issue(REQ_DISPATCH, 2'd0);

      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) begin
            // Extremes; the shorter period here leaves task zero's counter past it.
            next_period   = '{16'd1, 16'd65535, 16'd0, 16'd65535};
            next_deadline = '{16'd65535, 16'd1, 16'd0, 16'd0};
         end else begin
            // Active tasks' periods never shrink here, so no counter is stranded past its period.
            for (int t = 0; t < MAX_TASKS; t++) begin
               if (t < NUM_TASKS) begin
                  next_period[t]   = next_period[t] + CNT_W'($urandom_range(0, 3));
                  next_deadline[t] = CNT_W'($urandom_range(1, next_period[t] + 1));
               end else begin
                  next_period[t]   = CNT_W'($urandom_range(0, 65535));
                  next_deadline[t] = CNT_W'($urandom_range(0, 65535));
               end
            end
         end
         calm = 1'b0;
         apply_schedule();
         calm = (p % 3 == 2);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
               issue(REQ_TICK, TASK_IDX_W'($urandom_range(0, 3)));
            else if (r < 75)
               issue(REQ_DISPATCH, TASK_IDX_W'($urandom_range(0, 3)));
            else if (r < 95)
               issue(REQ_DONE, TASK_IDX_W'($urandom_range(0, 3)));
            else
               issue(REQ_UNUSED, TASK_IDX_W'($urandom_range(0, 3)));
         end
      end

      calm = 1'b0;
      wait_idle();
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #(CLK_PERIOD * 2_000_000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
